// ----- rtl/core/gsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package gsp_pkg;

  // Pool geometry and field widths
  localparam int SLOTS  = 16;
  localparam int SLOT_W = 4;
  localparam int GEN_W  = 16;
  localparam int TIME_W = 24;
  localparam int CNT_W  = 5;
  localparam int PRI_W  = 8;
  localparam int Q_W    = 16;
  localparam int FADE_W = 17;
  localparam int OUT_W  = 15;

  localparam logic [FADE_W-1:0] FADE_ONE = FADE_W'(1) << Q_W;

  // Operation codes
  localparam logic [1:0] OP_PLAY  = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_TICK  = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_PLAY  = 3'd0;
  localparam logic [2:0] KIND_STOP  = 3'd1;
  localparam logic [2:0] KIND_CLEAR = 3'd2;
  localparam logic [2:0] KIND_LIGHT = 3'd3;
  localparam logic [2:0] KIND_EMPTY = 3'd4;

  typedef struct packed {
    logic [1:0]         operation;
    logic [23:0]        duration;
    logic [7:0]         priority_req;
    logic               curve;
    logic signed [15:0] start_range;
    logic signed [15:0] end_range;
    logic signed [15:0] start_intensity;
    logic signed [15:0] end_intensity;
    logic [3:0]         handle_slot;
    logic [15:0]        handle_gen;
    logic [23:0]        delta_time;
    logic [4:0]         output_room;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        ok;
    logic [3:0]  slot_index;
    logic [15:0] generation;
    logic [16:0] fade_rate;
    logic [14:0] light_range;
    logic [14:0] light_intensity;
    logic        last;
  } out_word_t;

  // Datapath commands
  typedef enum logic [3:0] {
    CMD_NONE, CMD_PLAY, CMD_STOP, CMD_CLEAR, CMD_TINIT, CMD_EMPTY, CMD_SCAN, CMD_DINIT,
    CMD_DIV, CMD_FADE, CMD_QUINT, CMD_QEND, CMD_LERP_R, CMD_LERP_I, CMD_EMIT, CMD_AGE
  } cmd_t;

  typedef struct packed {
    logic load;
    cmd_t cmd;
  } ctl_t;

  typedef struct packed {
    logic [1:0] op;
    logic       no_rec;
    logic       scan_last;
    logic       div_last;
    logic       quint_last;
    logic       curve;
    logic       more_rec;
    logic       out_full;
  } sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/gsp_in_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface gsp_in_if;
  logic              valid;
  logic              ready;
  gsp_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gsp_out_if.sv -----
`timescale 1ns / 1ps
`default_nettype none

interface gsp_out_if;
  logic               valid;
  logic               ready;
  gsp_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/generational_slot_pool_with_lifetimes_core.sv -----
// Play, stop, clear: latch, decode, then the result loads once the output register is free.
// Tick: per record, a 16-slot priority scan, a 16-step restoring divider and, for ease-out records,
//   the curve steps, then a 16-slot ageing walk; with no records, an empty word comes before the walk.
// One item in flight; a finished result waits in the output register while the next is taken.
// Reset (rst_n low, synchronous): all slots free, generations and ages zero, stack pops slot 0 first.
`timescale 1ns / 1ps
`default_nettype none

module generational_slot_pool_with_lifetimes_core (
  input  wire logic clk,
  input  wire logic rst_n,
  gsp_in_if.sink    in_if,
  gsp_out_if.source out_if
);

  gsp_pkg::ctl_t ctl;
  gsp_pkg::sts_t sts;

  gsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  gsp_datapath u_datapath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_if.data),
    .ctl     (ctl),
    .sts     (sts),
    .out_if  (out_if)
  );

endmodule

`default_nettype wire

// ----- rtl/core/gsp_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gsp_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire gsp_pkg::sts_t sts,
  output gsp_pkg::ctl_t      ctl
);

  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_PLAY, S_STOP, S_CLEAR, S_TINIT, S_TCHK, S_EMPTY,
    S_SCAN, S_DINIT, S_DIV, S_FADE, S_QUINT, S_QEND, S_LR, S_LI, S_EMIT, S_AGE
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    ctl.load  = in_valid && (state_r == S_IDLE);
    ctl.cmd   = gsp_pkg::CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_DISPATCH;
      end
      S_DISPATCH: begin
        unique case (sts.op)
          gsp_pkg::OP_PLAY:  state_nxt = S_PLAY;
          gsp_pkg::OP_STOP:  state_nxt = S_STOP;
          gsp_pkg::OP_CLEAR: state_nxt = S_CLEAR;
          default:           state_nxt = S_TINIT;
        endcase
      end
      S_PLAY: begin
        if (!sts.out_full) begin
          ctl.cmd   = gsp_pkg::CMD_PLAY;
          state_nxt = S_IDLE;
        end
      end
      S_STOP: begin
        if (!sts.out_full) begin
          ctl.cmd   = gsp_pkg::CMD_STOP;
          state_nxt = S_IDLE;
        end
      end
      S_CLEAR: begin
        if (!sts.out_full) begin
          ctl.cmd   = gsp_pkg::CMD_CLEAR;
          state_nxt = S_IDLE;
        end
      end
      S_TINIT: begin
        ctl.cmd   = gsp_pkg::CMD_TINIT;
        state_nxt = S_TCHK;
      end
      S_TCHK: begin
        state_nxt = sts.no_rec ? S_EMPTY : S_SCAN;
      end
      S_EMPTY: begin
        if (!sts.out_full) begin
          ctl.cmd   = gsp_pkg::CMD_EMPTY;
          state_nxt = S_AGE;
        end
      end
      S_SCAN: begin
        ctl.cmd = gsp_pkg::CMD_SCAN;
        if (sts.scan_last) state_nxt = S_DINIT;
      end
      S_DINIT: begin
        ctl.cmd   = gsp_pkg::CMD_DINIT;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        ctl.cmd = gsp_pkg::CMD_DIV;
        if (sts.div_last) state_nxt = S_FADE;
      end
      S_FADE: begin
        ctl.cmd   = gsp_pkg::CMD_FADE;
        state_nxt = sts.curve ? S_QUINT : S_LR;
      end
      S_QUINT: begin
        ctl.cmd = gsp_pkg::CMD_QUINT;
        if (sts.quint_last) state_nxt = S_QEND;
      end
      S_QEND: begin
        ctl.cmd   = gsp_pkg::CMD_QEND;
        state_nxt = S_LR;
      end
      S_LR: begin
        ctl.cmd   = gsp_pkg::CMD_LERP_R;
        state_nxt = S_LI;
      end
      S_LI: begin
        ctl.cmd   = gsp_pkg::CMD_LERP_I;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!sts.out_full) begin
          ctl.cmd   = gsp_pkg::CMD_EMIT;
          state_nxt = sts.more_rec ? S_SCAN : S_AGE;
        end
      end
      S_AGE: begin
        ctl.cmd = gsp_pkg::CMD_AGE;
        if (sts.scan_last) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/gsp_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gsp_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire gsp_pkg::in_word_t in_data,
  input  wire gsp_pkg::ctl_t     ctl,
  output gsp_pkg::sts_t          sts,
  gsp_out_if.source              out_if
);

  localparam int SLOTS  = gsp_pkg::SLOTS;
  localparam int SLOT_W = gsp_pkg::SLOT_W;
  localparam int GEN_W  = gsp_pkg::GEN_W;
  localparam int TIME_W = gsp_pkg::TIME_W;
  localparam int CNT_W  = gsp_pkg::CNT_W;
  localparam int PRI_W  = gsp_pkg::PRI_W;
  localparam int Q_W    = gsp_pkg::Q_W;
  localparam int FADE_W = gsp_pkg::FADE_W;
  localparam int OUT_W  = gsp_pkg::OUT_W;

  // Interpolate packed {end, start}, round to nearest, clamp to 0..32767
  function automatic logic [OUT_W-1:0] lerp(input logic [31:0] pk,
                                            input logic [FADE_W-1:0] f);
    logic signed [16:0] s, e, d;
    logic signed [34:0] t;
    logic signed [18:0] q;
    logic signed [19:0] v;
    s = 17'($signed(pk[15:0]));
    e = 17'($signed(pk[31:16]));
    d = e - s;
    t = 35'(d) * 35'($signed({1'b0, f})) + 35'sd32768;
    q = $signed(t[34:16]);
    v = 20'(s) + 20'(q);
    if (v < 0) lerp = '0;
    else if (v > 20'sd32767) lerp = '1;
    else lerp = v[OUT_W-1:0];
  endfunction

  gsp_pkg::in_word_t req_r;

  // Slot state
  logic [SLOTS-1:0]  live_r;
  logic [GEN_W-1:0]  gen_r     [SLOTS];
  logic [TIME_W-1:0] elapsed_r [SLOTS];
  logic [TIME_W-1:0] dur_m     [SLOTS];
  logic [PRI_W-1:0]  pri_m     [SLOTS];
  logic              crv_m     [SLOTS];
  logic [31:0]       rng_m     [SLOTS];
  logic [31:0]       int_m     [SLOTS];
  logic [SLOT_W-1:0] stack_r   [SLOTS];
  logic [CNT_W-1:0]  fc_r;

  // Tick walk
  logic [SLOT_W-1:0] idx_r, pick_r;
  logic              pickv_r, prio_mode_r;
  logic [PRI_W-1:0]  pick_pri_r;
  logic [SLOTS-1:0]  taken_r;
  logic [CNT_W-1:0]  rec_n_r, nrec_r;

  // Fade arithmetic
  logic [TIME_W-1:0] dsr_r, rem_r;
  logic [Q_W-1:0]    q_r;
  logic [3:0]        step_r;
  logic              sat_r;
  logic [FADE_W-1:0] fade_r, u_r, p_r;
  logic [1:0]        mstep_r;
  logic [OUT_W-1:0]  lr_r, li_r;

  logic                out_valid_r;
  gsp_pkg::out_word_t  out_r, out_nxt;

  // Single read port over the slot arrays
  logic [SLOT_W-1:0] top_idx, addr;
  logic              a_live, a_crv;
  logic [GEN_W-1:0]  a_gen, new_gen;
  logic [TIME_W-1:0] a_el, a_dur, age_e;
  logic [PRI_W-1:0]  a_pri;
  logic [31:0]       a_rng, a_int;
  logic [CNT_W-1:0]  live_cnt, room_c;
  logic              play_ok, stop_ok, age_free, can_push, cand, out_full;
  logic [TIME_W:0]   age_sum;
  logic [TIME_W:0]   rem2;
  logic              div_ge;
  logic [2*FADE_W-1:0] qprod;

  assign top_idx = SLOT_W'(fc_r - CNT_W'(1));

  always_comb begin
    case (ctl.cmd)
      gsp_pkg::CMD_PLAY:                         addr = stack_r[top_idx];
      gsp_pkg::CMD_STOP:                         addr = req_r.handle_slot;
      gsp_pkg::CMD_DINIT, gsp_pkg::CMD_FADE, gsp_pkg::CMD_LERP_R,
      gsp_pkg::CMD_LERP_I:                       addr = pick_r;
      default:                                   addr = idx_r;
    endcase
  end

  assign a_live = live_r[addr];
  assign a_gen  = gen_r[addr];
  assign a_el   = elapsed_r[addr];
  assign a_dur  = dur_m[addr];
  assign a_pri  = pri_m[addr];
  assign a_crv  = crv_m[addr];
  assign a_rng  = rng_m[addr];
  assign a_int  = int_m[addr];

  assign live_cnt = CNT_W'($countones(live_r));
  assign room_c   = (req_r.output_room > CNT_W'(SLOTS)) ? CNT_W'(SLOTS) : req_r.output_room;

  assign new_gen  = (a_gen + GEN_W'(1) == '0) ? GEN_W'(1) : a_gen + GEN_W'(1);
  assign play_ok  = (req_r.duration != '0) && (fc_r != '0);
  assign stop_ok  = (req_r.handle_gen != '0) && a_live && (a_gen == req_r.handle_gen);
  assign can_push = (fc_r < CNT_W'(SLOTS));

  // Ageing: saturating add, free when the lifetime is used up
  assign age_sum  = {1'b0, a_el} + {1'b0, req_r.delta_time};
  assign age_e    = age_sum[TIME_W] ? '1 : age_sum[TIME_W-1:0];
  assign age_free = a_live && (age_e >= a_dur);

  assign cand = a_live && !taken_r[idx_r];

  // One restoring-division step per cycle
  assign rem2   = {rem_r, 1'b0};
  assign div_ge = rem2 >= {1'b0, dsr_r};

  assign qprod = p_r * u_r;

  assign out_full = out_valid_r && !out_if.ready;

  always_comb begin
    sts.op         = req_r.operation;
    sts.no_rec     = (nrec_r == '0);
    sts.scan_last  = (idx_r == SLOT_W'(SLOTS - 1));
    sts.div_last   = (step_r == 4'(Q_W - 1));
    sts.quint_last = (mstep_r == 2'd3);
    sts.curve      = a_crv;
    sts.more_rec   = (rec_n_r + CNT_W'(1)) < nrec_r;
    sts.out_full   = out_full;
  end

  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  // Request latch
  always_ff @(posedge clk) begin
    if (ctl.load) req_r <= in_data;
  end

  // Slot payload stores, written by play only
  always_ff @(posedge clk) begin
    if (ctl.cmd == gsp_pkg::CMD_PLAY && play_ok) begin
      dur_m[addr] <= req_r.duration;
      pri_m[addr] <= req_r.priority_req;
      crv_m[addr] <= req_r.curve;
      rng_m[addr] <= {req_r.end_range, req_r.start_range};
      int_m[addr] <= {req_r.end_intensity, req_r.start_intensity};
    end
  end

  // Live bits, generations, ages and free stack
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0;
      fc_r   <= CNT_W'(SLOTS);
      for (int i = 0; i < SLOTS; i++) begin
        gen_r[i]     <= '0;
        elapsed_r[i] <= '0;
        stack_r[i]   <= SLOT_W'(SLOTS - 1 - i);
      end
    end else begin
      unique case (ctl.cmd)
        gsp_pkg::CMD_PLAY: begin
          if (play_ok) begin
            gen_r[addr]     <= new_gen;
            live_r[addr]    <= 1'b1;
            elapsed_r[addr] <= '0;
            fc_r            <= fc_r - CNT_W'(1);
          end
        end
        gsp_pkg::CMD_STOP: begin
          if (stop_ok) begin
            live_r[addr]    <= 1'b0;
            elapsed_r[addr] <= '0;
            if (can_push) begin
              stack_r[fc_r[SLOT_W-1:0]] <= addr;
              fc_r                      <= fc_r + CNT_W'(1);
            end
          end
        end
        gsp_pkg::CMD_CLEAR: begin
          live_r <= '0;
          fc_r   <= CNT_W'(SLOTS);
          for (int i = 0; i < SLOTS; i++) begin
            elapsed_r[i] <= '0;
            stack_r[i]   <= SLOT_W'(SLOTS - 1 - i);
          end
        end
        gsp_pkg::CMD_AGE: begin
          if (age_free) begin
            live_r[addr]    <= 1'b0;
            elapsed_r[addr] <= '0;
            if (can_push) begin
              stack_r[fc_r[SLOT_W-1:0]] <= addr;
              fc_r                      <= fc_r + CNT_W'(1);
            end
          end else if (a_live) begin
            elapsed_r[addr] <= age_e;
          end
        end
        default: ;
      endcase
    end
  end

  // Tick walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      pickv_r     <= 1'b0;
      taken_r     <= '0;
      rec_n_r     <= '0;
      nrec_r      <= '0;
      prio_mode_r <= 1'b0;
      step_r      <= '0;
      mstep_r     <= '0;
    end else begin
      unique case (ctl.cmd)
        gsp_pkg::CMD_TINIT: begin
          nrec_r      <= (live_cnt < room_c) ? live_cnt : room_c;
          prio_mode_r <= live_cnt > room_c;
          rec_n_r     <= '0;
          taken_r     <= '0;
          idx_r       <= '0;
          pickv_r     <= 1'b0;
        end
        gsp_pkg::CMD_SCAN: begin
          if (cand && (!pickv_r || (prio_mode_r && a_pri > pick_pri_r))) pickv_r <= 1'b1;
          idx_r <= idx_r + SLOT_W'(1);
        end
        gsp_pkg::CMD_DINIT: begin
          taken_r[pick_r] <= 1'b1;
          step_r          <= '0;
        end
        gsp_pkg::CMD_DIV:   step_r  <= step_r + 4'd1;
        gsp_pkg::CMD_FADE:  mstep_r <= '0;
        gsp_pkg::CMD_QUINT: mstep_r <= mstep_r + 2'd1;
        gsp_pkg::CMD_EMIT: begin
          rec_n_r <= rec_n_r + CNT_W'(1);
          idx_r   <= '0;
          pickv_r <= 1'b0;
        end
        gsp_pkg::CMD_EMPTY: idx_r <= '0;
        gsp_pkg::CMD_AGE:   idx_r <= idx_r + SLOT_W'(1);
        default: ;
      endcase
    end
  end

  // Pick, divider, curve and interpolation registers
  always_ff @(posedge clk) begin
    case (ctl.cmd)
      gsp_pkg::CMD_SCAN: begin
        if (cand && (!pickv_r || (prio_mode_r && a_pri > pick_pri_r))) begin
          pick_r     <= idx_r;
          pick_pri_r <= a_pri;
        end
      end
      gsp_pkg::CMD_DINIT: begin
        rem_r <= a_el;
        dsr_r <= a_dur;
        sat_r <= a_el >= a_dur;
        q_r   <= '0;
      end
      gsp_pkg::CMD_DIV: begin
        rem_r <= div_ge ? TIME_W'(rem2 - {1'b0, dsr_r}) : rem2[TIME_W-1:0];
        q_r   <= {q_r[Q_W-2:0], div_ge};
      end
      gsp_pkg::CMD_FADE: begin
        fade_r <= sat_r ? gsp_pkg::FADE_ONE : {1'b0, q_r};
        u_r    <= gsp_pkg::FADE_ONE - (sat_r ? gsp_pkg::FADE_ONE : {1'b0, q_r});
        p_r    <= gsp_pkg::FADE_ONE - (sat_r ? gsp_pkg::FADE_ONE : {1'b0, q_r});
      end
      gsp_pkg::CMD_QUINT:  p_r    <= qprod[Q_W+FADE_W-1:Q_W];
      gsp_pkg::CMD_QEND:   fade_r <= gsp_pkg::FADE_ONE - p_r;
      gsp_pkg::CMD_LERP_R: lr_r   <= lerp(a_rng, fade_r);
      gsp_pkg::CMD_LERP_I: li_r   <= lerp(a_int, fade_r);
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      case (ctl.cmd)
        gsp_pkg::CMD_PLAY, gsp_pkg::CMD_STOP, gsp_pkg::CMD_CLEAR,
        gsp_pkg::CMD_EMPTY, gsp_pkg::CMD_EMIT: out_valid_r <= 1'b1;
        default: if (out_if.ready) out_valid_r <= 1'b0;
      endcase
    end
  end

  // Result word build
  always_comb begin
    out_nxt = out_r;
    case (ctl.cmd)
      gsp_pkg::CMD_PLAY: begin
        out_nxt            = '0;
        out_nxt.kind       = gsp_pkg::KIND_PLAY;
        out_nxt.ok         = play_ok;
        out_nxt.slot_index = play_ok ? addr : '0;
        out_nxt.generation = play_ok ? new_gen : '0;
        out_nxt.last       = 1'b1;
      end
      gsp_pkg::CMD_STOP: begin
        out_nxt            = '0;
        out_nxt.kind       = gsp_pkg::KIND_STOP;
        out_nxt.ok         = stop_ok;
        out_nxt.slot_index = req_r.handle_slot;
        out_nxt.generation = req_r.handle_gen;
        out_nxt.last       = 1'b1;
      end
      gsp_pkg::CMD_CLEAR: begin
        out_nxt      = '0;
        out_nxt.kind = gsp_pkg::KIND_CLEAR;
        out_nxt.last = 1'b1;
      end
      gsp_pkg::CMD_EMPTY: begin
        out_nxt      = '0;
        out_nxt.kind = gsp_pkg::KIND_EMPTY;
        out_nxt.last = 1'b1;
      end
      gsp_pkg::CMD_EMIT: begin
        out_nxt                 = '0;
        out_nxt.kind            = gsp_pkg::KIND_LIGHT;
        out_nxt.slot_index      = pick_r;
        out_nxt.fade_rate       = fade_r;
        out_nxt.light_range     = lr_r;
        out_nxt.light_intensity = li_r;
        out_nxt.last            = !sts.more_rec;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  // Every slot is either live or on the free stack
  a_pool_balance: assert property (@(posedge clk) disable iff (!rst_n)
    live_cnt + fc_r == CNT_W'(SLOTS))
    else $error("live count and free count disagree");

  a_clear_frees: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cmd == gsp_pkg::CMD_CLEAR |=> live_r == '0 && fc_r == CNT_W'(SLOTS))
    else $error("clear left slots in use");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.cmd == gsp_pkg::CMD_EMIT || ctl.cmd == gsp_pkg::CMD_EMPTY ||
     ctl.cmd == gsp_pkg::CMD_PLAY || ctl.cmd == gsp_pkg::CMD_STOP ||
     ctl.cmd == gsp_pkg::CMD_CLEAR) |-> !out_full)
    else $error("result word loaded over a pending word");

endmodule

`default_nettype wire

// ----- tb/gsp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module gsp_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  gsp_in_if.sink    in_mon,
  gsp_out_if.sink   out_mon,
  output int        fail_count,
  output int        pending_count
);
  import gsp_pkg::*;

  // shadow pool state
  logic              live_q  [SLOTS];
  logic [GEN_W-1:0]  gen_q   [SLOTS];
  logic [TIME_W-1:0] age_q   [SLOTS];
  logic [TIME_W-1:0] dur_q   [SLOTS];
  logic [PRI_W-1:0]  pri_q   [SLOTS];
  logic              curve_q [SLOTS];
  logic [31:0]       rng_q   [SLOTS];
  logic [31:0]       inten_q [SLOTS];
  logic [SLOT_W-1:0] free_stk[SLOTS];
  int                free_n;

  out_word_t expected_words[$];

  assign pending_count = expected_words.size();

  function automatic void refill_free();
    for (int i = 0; i < SLOTS; i++) free_stk[i] = SLOT_W'(SLOTS - 1 - i);
    free_n = SLOTS;
  endfunction

  function automatic void free_slot(int s);
    live_q[s] = 1'b0;
    age_q[s]  = '0;
    if (free_n < SLOTS) begin
      free_stk[free_n] = SLOT_W'(s);
      free_n++;
    end
  endfunction

  function automatic logic [FADE_W-1:0] slot_fade(int s);
    logic [63:0] r;
    logic [63:0] u;
    logic [63:0] p;
    r = ({40'd0, age_q[s]} << 16) / dur_q[s];
    if (r > 64'd65536) r = 64'd65536;
    if (!curve_q[s]) return FADE_W'(r);
    u = 64'd65536 - r;
    p = u;
    for (int k = 0; k < 4; k++) p = (p * u) >> 16;
    return FADE_W'(64'd65536 - p);
  endfunction

  function automatic logic [OUT_W-1:0] blend(logic [31:0] pk, logic [FADE_W-1:0] f);
    longint a;
    longint b;
    longint t;
    longint q;
    longint v;
    a = longint'($signed(pk[15:0]));
    b = longint'($signed(pk[31:16]));
    t = (b - a) * longint'(f) + 32768;
    q = (t >= 0) ? t / 65536 : -((-t + 65535) / 65536);
    v = a + q;
    if (v < 0) v = 0;
    if (v > 32767) v = 32767;
    return OUT_W'(v);
  endfunction

  // compute answers of one accepted word, update shadow state
  function automatic void pool_step(in_word_t w);
    out_word_t o;
    out_word_t outs[$];
    int s;
    int nlive;
    int room;
    bit taken[SLOTS];
    logic [GEN_W-1:0] g;
    logic [FADE_W-1:0] f;
    logic [TIME_W:0] e;
    case (w.operation)
      OP_PLAY: begin
        o = '0;
        o.kind = KIND_PLAY;
        if (w.duration != 0 && free_n > 0) begin
          free_n--;
          s = free_stk[free_n];
          g = gen_q[s] + 1'b1;
          if (g == 0) g = 1;
          gen_q[s] = g;
          live_q[s] = 1'b1;
          age_q[s] = '0;
          dur_q[s] = w.duration;
          pri_q[s] = w.priority_req;
          curve_q[s] = w.curve;
          rng_q[s] = {w.end_range, w.start_range};
          inten_q[s] = {w.end_intensity, w.start_intensity};
          o.ok = 1'b1;
          o.slot_index = SLOT_W'(s);
          o.generation = g;
        end
        outs = {outs, o};
      end
      OP_STOP: begin
        o = '0;
        o.kind = KIND_STOP;
        o.slot_index = w.handle_slot;
        o.generation = w.handle_gen;
        if (w.handle_gen != 0 && live_q[w.handle_slot] &&
            gen_q[w.handle_slot] == w.handle_gen) begin
          o.ok = 1'b1;
          free_slot(w.handle_slot);
        end
        outs = {outs, o};
      end
      OP_CLEAR: begin
        for (int i = 0; i < SLOTS; i++) begin
          live_q[i] = 1'b0;
          age_q[i] = '0;
        end
        refill_free();
        o = '0;
        o.kind = KIND_CLEAR;
        outs = {outs, o};
      end
      default: begin
        nlive = 0;
        for (int i = 0; i < SLOTS; i++) begin
          taken[i] = 0;
          if (live_q[i]) nlive++;
        end
        room = (w.output_room > SLOTS) ? SLOTS : int'(w.output_room);
        for (int k = 0; k < room && k < nlive; k++) begin
          s = -1;
          for (int i = 0; i < SLOTS; i++) begin
            if (!live_q[i] || taken[i]) continue;
            if (s < 0) begin
              s = i;
              if (nlive <= room) break;
            end else if (pri_q[i] > pri_q[s]) s = i;
          end
          taken[s] = 1;
          f = slot_fade(s);
          o = '0;
          o.kind = KIND_LIGHT;
          o.slot_index = SLOT_W'(s);
          o.fade_rate = f;
          o.light_range = blend(rng_q[s], f);
          o.light_intensity = blend(inten_q[s], f);
          outs = {outs, o};
        end
        if (outs.size() == 0) begin
          o = '0;
          o.kind = KIND_EMPTY;
          outs = {outs, o};
        end
        // age live slots, free expired ones in ascending order
        for (int i = 0; i < SLOTS; i++) begin
          if (!live_q[i]) continue;
          e = {1'b0, age_q[i]} + w.delta_time;
          if (e[TIME_W]) e = {1'b0, {TIME_W{1'b1}}};
          age_q[i] = e[TIME_W-1:0];
          if (age_q[i] >= dur_q[i]) free_slot(i);
        end
      end
    endcase
    outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) expected_words = {expected_words, outs[i]};
  endfunction

  // watch both channels at the rising edge
  always @(posedge clk) begin
    out_word_t exp_w;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        live_q[i] = 0; gen_q[i] = 0; age_q[i] = 0; dur_q[i] = 0;
        pri_q[i] = 0; curve_q[i] = 0; rng_q[i] = 0; inten_q[i] = 0;
      end
      refill_free();
      expected_words.delete();
      fail_count <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected result word %p", out_mon.data);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_mon.data !== exp_w) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: expected %p, got %p", exp_w, out_mon.data);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) pool_step(in_mon.data);
    end
  end
endmodule

`default_nettype wire

// ----- tb/tb_generational_slot_pool_with_lifetimes_core.sv -----
`timescale 1ns / 1ps
`default_nettype none

module tb_generational_slot_pool_with_lifetimes_core;
  import gsp_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending_count;
  int   ready_gap;
  logic [GEN_W-1:0] last_gen [SLOTS];

  gsp_in_if  in_ch ();
  gsp_out_if out_ch ();

  always #5 clk = ~clk;

  generational_slot_pool_with_lifetimes_core dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_ch.sink), .out_if(out_ch.source)
  );

  gsp_checker checker_i (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink),
    .fail_count(fail_count), .pending_count(pending_count)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
  end

  // remember handles handed out so stops often hit live slots
  always @(posedge clk) begin
    if (out_ch.valid && out_ch.ready && out_ch.data.kind == KIND_PLAY && out_ch.data.ok)
      last_gen[out_ch.data.slot_index] <= out_ch.data.generation;
  end

  // result side: random stalls, with calm stretches
  initial begin
    @(posedge clk iff rst_n);
    forever begin
      @(negedge clk);
      if (ready_gap > 0) begin
        out_ch.ready <= 1'b0;
        ready_gap--;
      end else begin
        out_ch.ready <= 1'b1;
        if (out_ch.valid && out_ch.ready) ready_gap = ($urandom_range(0, 3) == 0) ? 0 :
                                                      $urandom_range(0, 15);
      end
    end
  end

  task automatic send_word(in_word_t w, bit idle_ok);
    int gap;
    gap = idle_ok ? $urandom_range(0, 15) : 0;
    repeat (gap) @(negedge clk);
    in_ch.data  <= w;
    in_ch.valid <= 1'b1;
    @(posedge clk iff in_ch.ready);
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  function automatic in_word_t noise_word();
    in_word_t w;
    logic [159:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom};
    w = r[$bits(in_word_t)-1:0];
    return w;
  endfunction

  function automatic in_word_t play_word(logic [23:0] dur, logic [7:0] pri, logic crv);
    in_word_t w;
    w = noise_word();
    w.operation = OP_PLAY;
    w.duration = dur;
    w.priority_req = pri;
    w.curve = crv;
    return w;
  endfunction

  function automatic in_word_t tick_word(logic [23:0] dt, logic [4:0] room);
    in_word_t w;
    w = noise_word();
    w.operation = OP_TICK;
    w.delta_time = dt;
    w.output_room = room;
    return w;
  endfunction

  function automatic in_word_t stop_word(logic [3:0] s, logic [15:0] g);
    in_word_t w;
    w = noise_word();
    w.operation = OP_STOP;
    w.handle_slot = s;
    w.handle_gen = g;
    return w;
  endfunction

  initial begin
    in_word_t w;
    int pick;
    bit calm;
    ready_gap = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part
    send_word(tick_word(24'd5, 5'd16), 0);              // empty pool tick
    send_word(play_word(24'd0, 8'd9, 1'b0), 0);         // zero duration refused
    send_word(play_word(24'hFFFFFF, 8'hFF, 1'b1), 0);
    w = play_word(24'd100, 8'd0, 1'b0);
    w.start_range = 16'sh8000; w.end_range = 16'sh7FFF;
    w.start_intensity = 16'sh7FFF; w.end_intensity = 16'sh8000;
    send_word(w, 0);
    send_word(play_word(24'd1, 8'd0, 1'b1), 0);
    send_word(stop_word(4'd0, 16'd0), 0);               // invalid generation
    send_word(stop_word(4'd15, 16'd1), 0);              // slot not live
    send_word(stop_word(4'd1, 16'd2), 0);               // wrong generation
    send_word(tick_word(24'd50, 5'd0), 0);              // zero room
    send_word(tick_word(24'd0, 5'd2), 0);               // room equals live count, slot order
    send_word(tick_word(24'hFFFFFF, 5'd31), 0);         // saturating age, all expire
    for (int i = 0; i < 17; i++) send_word(play_word(24'd7, 8'(i), 1'b1), 0); // overfill
    send_word(stop_word(4'd3, 16'd1), 0);
    send_word(tick_word(24'd3, 5'd4), 0);
    send_word('{operation: OP_CLEAR, default: '0}, 0);
    // forget handles from before the clear
    for (int i = 0; i < 16; i++) last_gen[i] = 0;

    // random part
    for (int n = 0; n < 380; n++) begin
      calm = (n % 64) < 8;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        w = play_word(($urandom_range(0, 7) == 0) ? 24'($urandom) :
                      24'($urandom_range(0, 300)), 8'($urandom_range(0, 3) * 80),
                      1'($urandom));
        if ($urandom_range(0, 30) == 0) w.duration = 0;
      end else if (pick < 62) begin
        pick = $urandom_range(0, 15);
        w = stop_word(4'(pick), ($urandom_range(0, 4) == 0) ? 16'($urandom) : last_gen[pick]);
      end else if (pick < 65) begin
        w = noise_word();
        w.operation = OP_CLEAR;
      end else begin
        w = tick_word(($urandom_range(0, 9) == 0) ? 24'($urandom) :
                      24'($urandom_range(0, 60)), 5'($urandom_range(0, 31)));
      end
      send_word(w, !calm);
    end

    wait (pending_count == 0);
    repeat (400) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_generational_slot_pool_with_lifetimes_core: done, clean");
    end else begin
      $display("tb_generational_slot_pool_with_lifetimes_core: done, errors");
    end
    $finish;
  end

  initial begin
    #60ms;
    $display("tb_generational_slot_pool_with_lifetimes_core: done, errors");
    $finish;
  end
endmodule

`default_nettype wire

// ----- generational_slot_pool_with_lifetimes_core.f -----
rtl/core/gsp_pkg.sv
rtl/core/gsp_in_if.sv
rtl/core/gsp_out_if.sv
rtl/core/gsp_ctrl.sv
rtl/core/gsp_datapath.sv
rtl/core/generational_slot_pool_with_lifetimes_core.sv
tb/gsp_checker.sv
tb/tb_generational_slot_pool_with_lifetimes_core.sv
